[src/vma_pkg.sv]
package vma_pkg;

    // Field widths
    localparam int DATA_W    = 32;
    localparam int WIN_W     = 5;
    localparam int ACC_W     = DATA_W + WIN_W;
    localparam int DEPTH_DEF = 16;

    // Configuration port
    localparam int                APB_AW     = 3;
    localparam int                APB_DW     = 32;
    localparam logic [APB_AW-3:0] REG_WINDOW = '0;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_EMIT
    } t_state;

endpackage

[src/vma_req_if.sv]
interface vma_req_if
    import vma_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] sample_x;
    logic signed [DATA_W-1:0] sample_y;

    modport source (output valid, req_type, sample_x, sample_y, input ready);
    modport sink   (input valid, req_type, sample_x, sample_y, output ready);
endinterface

[src/vma_res_if.sv]
interface vma_res_if
    import vma_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     has_data;
    logic signed [DATA_W-1:0] avg_x;
    logic signed [DATA_W-1:0] avg_y;

    modport source (output valid, has_data, avg_x, avg_y, input ready);
    modport sink   (input valid, has_data, avg_x, avg_y, output ready);
endinterface

[src/vector_moving_average.sv]
// Channel   Direction  Handshake      Payload
// i_req     in         valid/ready    req_type, sample_x, sample_y
// o_res     out        valid/ready    has_data, avg_x, avg_y
// APB       in/out     psel/penable   paddr, pwdata, prdata (smoothing window at 0x0)
//
// An add or a clear is handled without leaving the idle state. For a query, the newest
// range samples are read one per cycle from the single read port of the sample memory,
// and each sum then goes through a divider that yields one bit per cycle. Reset is
// synchronous; the sample memory needs no clearing pass because the stored count keeps
// unwritten entries from being read. A finished result waits in the output register
// while adds and clears go on; a following query waits for that register to drain.
module vector_moving_average
    import vma_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vma_req_if.sink           i_req,
    vma_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > WIN_W) ? CW : WIN_W;
    localparam logic [WIN_W-1:0] WIN_MAX =
        (DEPTH < (2 ** WIN_W)) ? WIN_W'(DEPTH) : '1;
    localparam logic [SW-1:0]    SLOT_LAST = SW'(DEPTH - 1);
    localparam logic [CW-1:0]    CNT_FULL  = CW'(DEPTH);

    t_state                  r_state, n_state;
    logic [SW-1:0]           r_wslot, n_wslot;
    logic [SW-1:0]           r_newest, n_newest;
    logic [CW-1:0]           r_count, n_count;
    logic [WIN_W-1:0]        r_window, n_window;
    logic [SW-1:0]           r_addr, n_addr;
    logic [WIN_W-1:0]        r_left, n_left;
    logic                    r_pend, n_pend;
    logic signed [ACC_W-1:0] r_acc_x, n_acc_x;
    logic signed [ACC_W-1:0] r_acc_y, n_acc_y;
    logic [WIN_W-1:0]        r_range, n_range;
    logic                    r_has, n_has;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_has, n_out_has;
    logic [DATA_W-1:0]       r_out_x, n_out_x;
    logic [DATA_W-1:0]       r_out_y, n_out_y;

    logic                    in_acc;
    logic                    ram_we;
    logic [2*DATA_W-1:0]     ram_rdata;
    logic                    div_start;
    logic                    div_done_x, div_done_y;
    logic signed [DATA_W-1:0] quo_x, quo_y;
    logic [WIN_W-1:0]        eff_range;
    logic [WIN_W-1:0]        wr_win;
    logic                    cfg_wr;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;

    // Configuration: a write lands in the access phase, clamped to 1..DEPTH (at most 31).
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_WINDOW);
    assign prdata = (paddr[APB_AW-1:2] == REG_WINDOW) ?
                    {{(APB_DW-WIN_W){1'b0}}, r_window} : '0;

    always_comb begin
        wr_win = pwdata[WIN_W-1:0];
        if (wr_win == '0) begin
            wr_win = WIN_W'(1);
        end else if (wr_win > WIN_MAX) begin
            wr_win = WIN_MAX;
        end
    end

    // The window never covers more samples than the store holds.
    assign eff_range = (MW'(r_window) > MW'(r_count)) ? WIN_W'(r_count) : r_window;

    assign ram_we = in_acc && (i_req.req_type == REQ_ADD);

    vma_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (DEPTH),
        .AW    (SW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wslot),
        .i_wdata ({i_req.sample_x, i_req.sample_y}),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign div_start = (r_state == S_READ) && (r_left == '0) && !r_pend;

    vma_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc_x),
        .i_divisor  (r_range),
        .o_done     (div_done_x),
        .o_quotient (quo_x)
    );

    vma_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc_y),
        .i_divisor  (r_range),
        .o_done     (div_done_y),
        .o_quotient (quo_y)
    );

    always_comb begin
        n_state     = r_state;
        n_wslot     = r_wslot;
        n_newest    = r_newest;
        n_count     = r_count;
        n_window    = cfg_wr ? wr_win : r_window;
        n_addr      = r_addr;
        n_left      = r_left;
        n_pend      = 1'b0;
        n_acc_x     = r_acc_x;
        n_acc_y     = r_acc_y;
        n_range     = r_range;
        n_has       = r_has;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_has   = r_out_has;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority case (i_req.req_type)
                        REQ_ADD: begin
                            n_newest = r_wslot;
                            n_wslot  = (r_wslot == SLOT_LAST) ? '0 : r_wslot + 1'b1;
                            if (r_count != CNT_FULL) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        REQ_QUERY: begin
                            n_acc_x = '0;
                            n_acc_y = '0;
                            n_addr  = r_newest;
                            n_left  = eff_range;
                            n_range = eff_range;
                            if (r_count == '0) begin
                                n_has   = 1'b0;
                                n_state = S_EMIT;
                            end else begin
                                n_has   = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        REQ_CLEAR: begin
                            n_newest = '0;
                            n_wslot  = '0;
                            n_count  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                // One read issued per cycle, newest first; data lands in the following cycle.
                if (r_left != '0) begin
                    n_addr = (r_addr == '0) ? SLOT_LAST : r_addr - 1'b1;
                    n_left = r_left - 1'b1;
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    n_acc_x = r_acc_x + ACC_W'($signed(ram_rdata[2*DATA_W-1:DATA_W]));
                    n_acc_y = r_acc_y + ACC_W'($signed(ram_rdata[DATA_W-1:0]));
                end
                if (div_start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done_x && div_done_y) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_has   = r_has;
                    n_out_x     = r_has ? quo_x : '0;
                    n_out_y     = r_has ? quo_y : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wslot     <= '0;
            r_newest    <= '0;
            r_count     <= '0;
            r_window    <= WIN_W'(1);
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wslot     <= n_wslot;
            r_newest    <= n_newest;
            r_count     <= n_count;
            r_window    <= n_window;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_acc_x   <= n_acc_x;
        r_acc_y   <= n_acc_y;
        r_range   <= n_range;
        r_has     <= n_has;
        r_out_has <= n_out_has;
        r_out_x   <= n_out_x;
        r_out_y   <= n_out_y;
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.has_data = r_out_has;
    assign o_res.avg_x    = r_out_x;
    assign o_res.avg_y    = r_out_y;

endmodule

[src/vma_ram.sv]
module vma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/vma_div.sv]
module vma_div
    import vma_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [ACC_W-1:0]  i_dividend,
    input  logic [WIN_W-1:0]         i_divisor,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [ACC_W-1:0] r_q, n_q;
    logic [WIN_W:0]   r_rem, n_rem;
    logic [WIN_W-1:0] r_div, n_div;
    logic             r_neg, n_neg;
    logic [WIN_W:0]   rem_sh;

    // Restoring division on the magnitude, one quotient bit per cycle.
    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        n_neg  = r_neg;
        rem_sh = {r_rem[WIN_W-1:0], r_q[ACC_W-1]};
        if (i_start) begin
            n_neg = i_dividend[ACC_W-1];
            n_q   = i_dividend[ACC_W-1] ? ACC_W'(-i_dividend) : ACC_W'(i_dividend);
            n_rem = '0;
            n_div = i_divisor;
            n_cnt = CNT_W'(ACC_W);
        end else if (r_cnt != '0) begin
            if (rem_sh >= {1'b0, r_div}) begin
                n_rem = rem_sh - {1'b0, r_div};
                n_q   = {r_q[ACC_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_q   = {r_q[ACC_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? DATA_W'(-r_q[DATA_W-1:0]) : r_q[DATA_W-1:0];

endmodule

[src/vma_chk.sv]
module vma_chk
    import vma_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [1:0]        in_req_type,
    input logic              out_valid,
    input logic              out_ready,
    input logic              out_has_data,
    input logic [DATA_W-1:0] out_avg_x,
    input logic [DATA_W-1:0] out_avg_y
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_avg_x) && $stable(out_avg_y)
            && $stable(out_has_data))
        else $error("result changed while stalled");

    // An empty store reports a zero average.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_has_data |-> out_avg_x == '0 && out_avg_y == '0)
        else $error("empty result with nonzero average");

    // A query holds off the next item while it is worked on.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_req_type == REQ_QUERY |=> !in_ready)
        else $error("item accepted during a query");

    // Reset leaves no result pending.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind vector_moving_average vma_chk u_vma_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_valid     (i_req.valid),
    .in_ready     (i_req.ready),
    .in_req_type  (i_req.req_type),
    .out_valid    (o_res.valid),
    .out_ready    (o_res.ready),
    .out_has_data (o_res.has_data),
    .out_avg_x    (o_res.avg_x),
    .out_avg_y    (o_res.avg_y)
);
